>>> rtl/ple_pkg.sv
// Shared types and constants for the positional list engine.
package ple_pkg;

  // Fixed field widths
  localparam int unsigned DATA_W = 32;
  localparam int unsigned POS_W  = 10;
  localparam int unsigned LEN_W  = 11;

  // Cells per first-level reduction group
  localparam int unsigned GROUP_SZ  = 8;
  localparam int unsigned GRP_IDX_W = $clog2(GROUP_SZ);

  typedef enum logic [1:0] {
    OP_GET    = 2'd0,
    OP_LOCATE = 2'd1,
    OP_INSERT = 2'd2,
    OP_DELETE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_FINISH
  } state_e;

  // Request item
  typedef struct packed {
    logic [1:0]               req_type;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
  } req_t;

  // Result item
  typedef struct packed {
    logic                     ok;
    logic signed [DATA_W-1:0] read_value;
    logic [LEN_W-1:0]         found_position;
    logic [LEN_W-1:0]         list_length;
  } rsp_t;

  // Broadcast control from the sequencer to every cell
  typedef struct packed {
    logic              shift_up;
    logic              shift_dn;
    logic [LEN_W-1:0]  position;
    logic [DATA_W-1:0] value;
    logic [LEN_W-1:0]  length;
  } cell_ctrl_t;

  // Registered summary of one group of cells
  typedef struct packed {
    logic                 hit;
    logic [GRP_IDX_W-1:0] loc;
    logic [DATA_W-1:0]    rd;
  } grp_rsp_t;

endpackage

>>> rtl/ple_cell.sv
// One list cell: holds one entry, shifts with its neighbors, flags match and select.
module ple_cell
  import ple_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic              clk_i,
  input  cell_ctrl_t        ctrl_i,
  input  logic [DATA_W-1:0] left_i,
  input  logic [DATA_W-1:0] right_i,
  output logic [DATA_W-1:0] entry_o,
  output logic              match_o,
  output logic              sel_o
);

  // 1-based position of this cell
  localparam logic [LEN_W-1:0] Pos1 = LEN_W'(IDX + 1);

  logic [DATA_W-1:0] entry_q, entry_d;

  // Shift up on insert, down on delete, at and above the target position
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.shift_up && (Pos1 >= ctrl_i.position)) begin
      entry_d = (Pos1 == ctrl_i.position) ? ctrl_i.value : left_i;
    end else if (ctrl_i.shift_dn && (Pos1 >= ctrl_i.position)) begin
      entry_d = right_i;
    end
  end

  // Entry storage, undefined until written
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  assign match_o = (entry_q == ctrl_i.value) && (Pos1 <= ctrl_i.length);
  assign sel_o   = (Pos1 == ctrl_i.position);

endmodule

>>> rtl/ple_group.sv
// First-level reduction over a group of cells: first match and selected entry.
module ple_group
  import ple_pkg::*;
(
  input  logic                             clk_i,
  input  logic [GROUP_SZ-1:0]              match_i,
  input  logic [GROUP_SZ-1:0]              sel_i,
  input  logic [GROUP_SZ-1:0][DATA_W-1:0]  data_i,
  output grp_rsp_t                         grp_o
);

  grp_rsp_t grp_d, grp_q;

  // Lowest matching cell wins; select is one-hot so an OR picks the entry
  always_comb begin
    grp_d = '0;
    for (int j = GROUP_SZ - 1; j >= 0; j--) begin
      if (match_i[j]) begin
        grp_d.hit = 1'b1;
        grp_d.loc = GRP_IDX_W'(j);
      end
      grp_d.rd = grp_d.rd | (data_i[j] & {DATA_W{sel_i[j]}});
    end
  end

  always_ff @(posedge clk_i) begin
    grp_q <= grp_d;
  end

  assign grp_o = grp_q;

endmodule

>>> rtl/positional_list_engine_top.sv
// Positional list engine: row of entry cells, two-level reduction and sequencer.
// A taken request is registered, its group summaries are registered in REDUCE, and its
// result is registered at the end of FINISH and strobed on done_o. Busy is high in
// REDUCE and FINISH (row reduction and shift), so no request is taken until both end.
// Reset clears the length and the sequencer; entry cells are not reset and are only
// read at positions that have been written. The receiver cannot stall results.
module positional_list_engine_top
  import ple_pkg::*;
#(
  parameter int CAPACITY = 256
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  input  req_t req_i,
  output logic busy,
  output logic done_o,
  output rsp_t rsp_o
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int NG = (CAPACITY + GROUP_SZ - 1) / GROUP_SZ;
  localparam int NP = NG * GROUP_SZ;
  localparam logic [LEN_W-1:0] CapLen = LEN_W'(CAPACITY);

  state_e state_q, state_d;
  req_t   req_q;
  logic [CW-1:0] count_q, count_d;
  logic   done_q, done_d;
  rsp_t   rsp_q, rsp_d;

  cell_ctrl_t ctrl;
  logic [CAPACITY-1:0][DATA_W-1:0] entry_w;
  logic [NP-1:0]                   match_w, sel_w;
  logic [NP-1:0][DATA_W-1:0]       data_w;
  grp_rsp_t                        grp_w [NG];

  logic       accept;
  op_e        op;
  logic [LEN_W-1:0] pos, len;
  logic       pos_ok, ins_ok;
  logic       any_hit;
  logic [LEN_W-1:0] fpos;
  logic [DATA_W-1:0] rd_all;
  logic       ok, do_ins, do_del;

  assign accept = start && !busy;
  assign op     = op_e'(req_q.req_type);
  assign pos    = LEN_W'(req_q.position);
  assign len    = LEN_W'(count_q);
  assign pos_ok = (pos != '0) && (pos <= len);
  assign ins_ok = (pos != '0) && (pos <= len + LEN_W'(1)) && (len < CapLen);

  // Request capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
  end

  // Cell row
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] left_w, right_w;
    if (i == 0) begin : g_first
      assign left_w = ctrl.value;
    end else begin : g_mid_l
      assign left_w = entry_w[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w = ctrl.value;
    end else begin : g_mid_r
      assign right_w = entry_w[i+1];
    end
    ple_cell #(.IDX(i)) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .left_i  (left_w),
      .right_i (right_w),
      .entry_o (entry_w[i]),
      .match_o (match_w[i]),
      .sel_o   (sel_w[i])
    );
    assign data_w[i] = entry_w[i];
  end

  // Pad the last group
  for (genvar i = CAPACITY; i < NP; i++) begin : g_pad
    assign match_w[i] = 1'b0;
    assign sel_w[i]   = 1'b0;
    assign data_w[i]  = '0;
  end

  // First reduction level
  for (genvar g = 0; g < NG; g++) begin : g_grp
    ple_group u_grp (
      .clk_i   (clk_i),
      .match_i (match_w[g*GROUP_SZ +: GROUP_SZ]),
      .sel_i   (sel_w[g*GROUP_SZ +: GROUP_SZ]),
      .data_i  (data_w[g*GROUP_SZ +: GROUP_SZ]),
      .grp_o   (grp_w[g])
    );
  end

  // Second reduction level over the group summaries
  always_comb begin
    any_hit = 1'b0;
    fpos    = '0;
    rd_all  = '0;
    for (int g = NG - 1; g >= 0; g--) begin
      if (grp_w[g].hit) begin
        any_hit = 1'b1;
        fpos    = LEN_W'(g * GROUP_SZ) + LEN_W'(grp_w[g].loc) + LEN_W'(1);
      end
      rd_all = rd_all | grp_w[g].rd;
    end
  end

  // Operation decode
  always_comb begin
    ok = 1'b0;
    unique case (op)
      OP_GET:    ok = pos_ok;
      OP_LOCATE: ok = any_hit;
      OP_INSERT: ok = ins_ok;
      OP_DELETE: ok = pos_ok;
      default:   ok = 1'b0;
    endcase
  end

  assign do_ins = (op == OP_INSERT) && ins_ok;
  assign do_del = (op == OP_DELETE) && pos_ok;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (accept) state_d = ST_REDUCE;
      ST_REDUCE: state_d = ST_FINISH;
      ST_FINISH: state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    busy          = (state_q != ST_IDLE);
    ctrl.shift_up = 1'b0;
    ctrl.shift_dn = 1'b0;
    ctrl.position = pos;
    ctrl.value    = req_q.value;
    ctrl.length   = len;
    count_d       = count_q;
    done_d        = 1'b0;
    rsp_d         = rsp_q;
    unique case (state_q)
      ST_FINISH: begin
        ctrl.shift_up = do_ins;
        ctrl.shift_dn = do_del;
        if (do_ins) begin
          count_d = count_q + CW'(1);
        end else if (do_del) begin
          count_d = count_q - CW'(1);
        end
        done_d               = 1'b1;
        rsp_d.ok             = ok;
        rsp_d.read_value     = (ok && ((op == OP_GET) || (op == OP_DELETE))) ? rd_all : '0;
        rsp_d.found_position = (op == OP_LOCATE) ? fpos : '0;
        rsp_d.list_length    = LEN_W'(count_d);
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // Checks
  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result strobed while busy");

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy && !done_o)) else $error("accepted request did not start");

  a_len_cap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (rsp_o.list_length <= CapLen)) else $error("length above capacity");

  a_fpos_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (rsp_o.found_position != '0)) |-> rsp_o.ok)
    else $error("found position without ok");

endmodule

>>> tb/positional_list_engine_top_tb.sv
// Self-checking testbench for the positional list engine: shadow list, directed and random requests.
`timescale 1ns / 100ps

module positional_list_engine_top_tb
  import ple_pkg::*;
;

  localparam int CAP = 256;
  localparam int N_RANDOM = 1225;
  localparam int QUIET_TAIL = 150;
  localparam int CYCLE_LIMIT = 300000;

  typedef enum {MODE_FILL, MODE_MIX, MODE_DRAIN} mix_e;

  // Shadow copy of the list; predicts each reply and checks what the block returns
  class list_shadow;
    logic signed [DATA_W-1:0] slots[];
    int unsigned cap;
    int unsigned fill;
    rsp_t pending_replies[$];
    int errors;
    int ops_seen[4];
    int refused;
    int full_refused;
    int unsigned peak;

    function new(int unsigned capacity);
      cap = capacity;
      slots = new[capacity];
      fill = 0;
      errors = 0;
      refused = 0;
      full_refused = 0;
      peak = 0;
      foreach (ops_seen[i]) ops_seen[i] = 0;
    endfunction

    task report(string what, longint got, longint want);
      $display("  mismatch on %s: got %0h, want %0h", what, got, want);
      errors++;
    endtask

    // Apply one accepted request to the shadow list and queue its reply
    function void note_request(req_t r);
      rsp_t want;
      int unsigned pos;
      int unsigned k;
      want = '0;
      pos = r.position;
      ops_seen[r.req_type]++;
      case (r.req_type)
        OP_GET: begin
          if (pos >= 1 && pos <= fill) begin
            want.read_value = slots[pos-1];
            want.ok = 1'b1;
          end
        end
        OP_LOCATE: begin
          // lowest matching position wins
          for (k = 0; k < fill; k++) begin
            if (slots[k] == r.value) begin
              want.found_position = LEN_W'(k + 1);
              want.ok = 1'b1;
              break;
            end
          end
        end
        OP_INSERT: begin
          if (pos >= 1 && pos <= fill + 1 && fill < cap) begin
            for (k = fill; k > pos - 1; k--) slots[k] = slots[k-1];
            slots[pos-1] = r.value;
            fill++;
            want.ok = 1'b1;
          end else if (fill == cap) begin
            full_refused++;
          end
        end
        default: begin
          if (pos >= 1 && pos <= fill) begin
            want.read_value = slots[pos-1];
            for (k = pos; k < fill; k++) slots[k-1] = slots[k];
            fill--;
            want.ok = 1'b1;
          end
        end
      endcase
      if (!want.ok) refused++;
      if (fill > peak) peak = fill;
      want.list_length = LEN_W'(fill);
      pending_replies.push_back(want);
    endfunction

    // Compare one strobed reply with the oldest prediction
    task check_response(rsp_t got);
      rsp_t want;
      if (pending_replies.size() == 0) begin
        report("unexpected reply, length", got.list_length, 0);
      end else begin
        want = pending_replies.pop_front();
        if (got.ok !== want.ok) report("ok", got.ok, want.ok);
        if (got.read_value !== want.read_value)
          report("read_value", got.read_value, want.read_value);
        if (got.found_position !== want.found_position)
          report("found_position", got.found_position, want.found_position);
        if (got.list_length !== want.list_length)
          report("list_length", got.list_length, want.list_length);
      end
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  req_t req_i = '0;
  logic busy;
  logic done_o;
  rsp_t rsp_o;

  list_shadow sb;
  int cycle_count = 0;

  positional_list_engine_top #(.CAPACITY(CAP)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .req_i  (req_i),
    .busy   (busy),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  // Clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("run limit reached with %0d replies outstanding",
               sb.pending_replies.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // Monitor: replies are checked before the request taken on the same edge is noted
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) sb.check_response(rsp_o);
      if (start && !busy) sb.note_request(req_i);
    end
  end

  function automatic req_t make_req(op_e op, int unsigned pos, logic [DATA_W-1:0] val);
    req_t r;
    r.req_type = op;
    r.position = POS_W'(pos);
    r.value = val;
    return r;
  endfunction

  // Hold a request until the block takes it; returns on the following falling edge
  task automatic send_request(req_t r);
    start <= 1'b1;
    req_i <= r;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic hold_off(int n);
    start <= 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  task automatic wait_drain();
    start <= 1'b0;
    while (sb.pending_replies.size() != 0) @(negedge clk_i);
  endtask

  // Position in 1..hi, leaning on the ends
  function automatic int unsigned pick_pos(int unsigned hi);
    int unsigned w;
    w = $urandom_range(0, 99);
    if (w < 8) return 1;
    if (w < 16) return hi;
    return $urandom_range(1, hi);
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    int unsigned w;
    w = $urandom_range(0, 99);
    if (w < 20) return DATA_W'($signed($urandom_range(0, 6)) - 3);
    if (w < 25) return 32'h7fff_ffff;
    if (w < 30) return 32'h8000_0000;
    return $urandom;
  endfunction

  function automatic req_t random_request(mix_e mode);
    int unsigned w;
    op_e op;
    int unsigned pos;
    logic [DATA_W-1:0] val;
    w = $urandom_range(0, 99);
    case (mode)
      MODE_FILL:  op = (w < 60) ? OP_INSERT : (w < 75) ? OP_GET : (w < 90) ? OP_LOCATE : OP_DELETE;
      MODE_DRAIN: op = (w < 60) ? OP_DELETE : (w < 75) ? OP_GET : (w < 90) ? OP_LOCATE : OP_INSERT;
      default:    op = op_e'(w / 25);
    endcase
    val = pick_value();
    // locate mostly searches for something already stored
    if (op == OP_LOCATE && sb.fill > 0 && $urandom_range(0, 99) < 60)
      val = sb.slots[$urandom_range(0, sb.fill - 1)];
    w = $urandom_range(0, 99);
    if (w < 4) begin
      pos = $urandom_range(0, 1023);
    end else if (w < 7) begin
      pos = 0;
    end else if (w < 10) begin
      pos = (op == OP_INSERT) ? sb.fill + 2 : sb.fill + 1;
    end else if (op == OP_INSERT) begin
      pos = pick_pos(sb.fill + 1);
    end else if (sb.fill == 0) begin
      pos = $urandom_range(0, 1023);
    end else begin
      pos = pick_pos(sb.fill);
    end
    return make_req(op, pos, val);
  endfunction

  // Stimulus
  initial begin
    mix_e mode;
    int full_hold;
    int mix_left;
    bit idle_on;
    sb = new(CAP);
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: empty list, range edges, signed extremes, duplicates, delete to empty
    send_request(make_req(OP_GET, 1, 0));
    send_request(make_req(OP_LOCATE, 0, 0));
    send_request(make_req(OP_DELETE, 1, 0));
    send_request(make_req(OP_INSERT, 0, 32'h1));
    send_request(make_req(OP_INSERT, 2, 32'h2));
    send_request(make_req(OP_INSERT, 1, 32'h7fff_ffff));
    send_request(make_req(OP_INSERT, 1, 32'h8000_0000));
    send_request(make_req(OP_INSERT, 3, 32'hffff_ffff));
    send_request(make_req(OP_INSERT, 2, 32'h0));
    send_request(make_req(OP_INSERT, 5, 32'h7fff_ffff));
    send_request(make_req(OP_GET, 0, 0));
    send_request(make_req(OP_GET, 5, 0));
    send_request(make_req(OP_GET, 6, 0));
    send_request(make_req(OP_GET, 1023, 32'hffff_ffff));
    send_request(make_req(OP_LOCATE, 1023, 32'h7fff_ffff));
    send_request(make_req(OP_LOCATE, 0, 32'h1234_5678));
    send_request(make_req(OP_LOCATE, 512, 32'h8000_0000));
    send_request(make_req(OP_DELETE, 1023, 0));
    send_request(make_req(OP_INSERT, 1023, 32'h5a5a_5a5a));
    send_request(make_req(OP_DELETE, 1, 0));
    send_request(make_req(OP_DELETE, 4, 0));
    send_request(make_req(OP_DELETE, 2, 0));
    send_request(make_req(OP_GET, 1, 0));
    send_request(make_req(OP_DELETE, 1, 0));
    send_request(make_req(OP_DELETE, 1, 0));
    wait_drain();

    // Random: fill to capacity, hammer the full list, drain to empty, mix, repeat
    mode = MODE_FILL;
    full_hold = 0;
    mix_left = 0;
    idle_on = 1'b1;
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 64 == 0) idle_on = $urandom_range(0, 2) != 0;
      if (i >= N_RANDOM - QUIET_TAIL) idle_on = 1'b0;
      if (idle_on && $urandom_range(0, 3) == 0) hold_off($urandom_range(1, 8));
      send_request(random_request(mode));
      if (i % 400 == 399 && i < N_RANDOM - QUIET_TAIL) wait_drain();
      case (mode)
        MODE_FILL: begin
          if (sb.fill == CAP) full_hold++;
          if (full_hold > 12) begin
            mode = MODE_DRAIN;
            full_hold = 0;
          end
        end
        MODE_DRAIN: begin
          if (sb.fill == 0) begin
            mode = MODE_MIX;
            mix_left = 120;
          end
        end
        default: begin
          mix_left--;
          if (mix_left <= 0) mode = MODE_FILL;
        end
      endcase
    end

    // Let the last replies arrive, then a few quiet cycles
    wait_drain();
    repeat (6) @(negedge clk_i);

    $display("requests: %0d get, %0d locate, %0d insert, %0d delete; %0d refused",
             sb.ops_seen[OP_GET], sb.ops_seen[OP_LOCATE], sb.ops_seen[OP_INSERT],
             sb.ops_seen[OP_DELETE], sb.refused);
    $display("peak length %0d of %0d, %0d inserts refused on a full list, %0d mismatches",
             sb.peak, CAP, sb.full_refused, sb.errors);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
